/* src/mm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the matrix multiply block.
// No dependencies.
package mm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;

   localparam int IDX_W  = 3;   // row / column / inner index fields
   localparam int DIM_W  = 4;   // dimension registers
   localparam int DATA_W = 32;  // Q16.16 element
   localparam int PROD_W = 64;  // Q32.32 product; Q48.16 accumulator
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W  = 2;

   localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic             first;     // first term of a product element
      logic             last;      // last term of a product element
      logic             last_run;  // last term of the whole run
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mm_tag_type;

   typedef struct packed {
      logic             issue;
      logic             load_a;
      logic             load_b;
      logic [IDX_W-1:0] k;
      mm_tag_type       tag;
   } mm_cmd_type;

   typedef struct packed {
      logic run_done;
   } mm_sts_type;

   // 0 acts as 1, anything above the limit acts as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0)
         r = DIM_W'(1);
      else if (v > lim)
         r = lim;
      else
         r = v;
      return r;
   endfunction

endpackage

/* src/mm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/mm_ctrl.sv */
`timescale 1ns / 1ps
// Controller: dimension registers, request decode and the i/j/k walk of a run.
// Depends on mm_pkg.
module mm_ctrl
   import mm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [REQ_W-1:0]     req_type,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  mm_sts_type           sts,
   output mm_cmd_type           cmd,
   output logic                 busy
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] nr_ff, nk_ff, nc_ff;
   logic [DIM_W-1:0] nr_in, nk_in, nc_in;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic             accept;
   logic             k_end, j_end, i_end;

   assign accept = start && (state_ff == ST_IDLE);
   assign k_end  = ({1'b0, k_ff} == nk_ff - DIM_W'(1));
   assign j_end  = ({1'b0, j_ff} == nc_ff - DIM_W'(1));
   assign i_end  = ({1'b0, i_ff} == nr_ff - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in  = i_ff;
      j_in  = j_ff;
      k_in  = k_ff;
      nr_in = nr_ff;
      nk_in = nk_ff;
      nc_in = nc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_COMPUTE) begin
               nr_in = clamp_dim(rows_a_ff, DIM_LIM);
               nk_in = clamp_dim(inner_dim_ff, DIM_LIM);
               nc_in = clamp_dim(cols_b_ff, DIM_LIM);
               i_in  = '0;
               j_in  = '0;
               k_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!k_end) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!j_end) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (i_end) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (sts.run_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff  <= '0;
         j_ff  <= '0;
         k_ff  <= '0;
         nr_ff <= DIM_W'(1);
         nk_ff <= DIM_W'(1);
         nc_ff <= DIM_W'(1);
      end else begin
         state_ff <= state_in;
         i_ff  <= i_in;
         j_ff  <= j_in;
         k_ff  <= k_in;
         nr_ff <= nr_in;
         nk_ff <= nk_in;
         nc_ff <= nc_in;
      end
   end

   always_comb begin
      cmd.issue        = (state_ff == ST_RUN);
      cmd.load_a       = accept && (req_type == REQ_LOAD_A);
      cmd.load_b       = accept && (req_type == REQ_LOAD_B);
      cmd.k            = k_ff;
      cmd.tag.first    = (k_ff == '0);
      cmd.tag.last     = k_end;
      cmd.tag.last_run = k_end && j_end && i_end;
      cmd.tag.row      = i_ff;
      cmd.tag.col      = j_ff;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* src/mm_dp.sv */
`timescale 1ns / 1ps
// Datapath: the two element stores, multiplier, accumulator and result register.
// Depends on mm_pkg and mm_ram.
module mm_dp
   import mm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mm_cmd_type               cmd,
   input  logic [IDX_W-1:0]         req_element_row,
   input  logic [IDX_W-1:0]         req_element_col,
   input  logic signed [DATA_W-1:0] req_element_value,
   output mm_sts_type               sts,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_last_of_run
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(64'sd2147483648);

   logic          in_range;
   logic [AW-1:0] waddr, a_raddr, b_raddr;
   logic [DATA_W-1:0] a_rdata, b_rdata;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mm_tag_type        s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] term;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] sat_value;

   logic                     rsp_valid_ff, rsp_last_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;

   assign in_range = (int'(req_element_row) < MAX_DIM) && (int'(req_element_col) < MAX_DIM);
   assign waddr    = AW'(int'(req_element_row) * MAX_DIM + int'(req_element_col));
   assign a_raddr  = AW'(int'(cmd.tag.row) * MAX_DIM + int'(cmd.k));
   assign b_raddr  = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.tag.col));

   mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
      .clock (clock),
      .we    (cmd.load_a && in_range),
      .waddr (waddr),
      .wdata (req_element_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
      .clock (clock),
      .we    (cmd.load_b && in_range),
      .waddr (waddr),
      .wdata (req_element_value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   assign prod_in = PROD_W'($signed(a_rdata)) * PROD_W'($signed(b_rdata));

   // arithmetic shift of the Q32.32 product is the floor to Q16.16
   assign term   = prod_ff >>> FRAC_BITS;
   assign acc_in = (s2_tag_ff.first ? '0 : acc_ff) + term;

   always_comb begin
      if (acc_ff > SAT_HI)
         sat_value = DATA_W'(SAT_HI);
      else if (acc_ff < SAT_LO)
         sat_value = DATA_W'(SAT_LO);
      else
         sat_value = DATA_W'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_tag_ff.last;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      if (s2_valid_ff) begin
         acc_ff    <= acc_in;
         s3_tag_ff <= s2_tag_ff;
      end
      rsp_row_ff   <= s3_tag_ff.row;
      rsp_col_ff   <= s3_tag_ff.col;
      rsp_value_ff <= sat_value;
      rsp_last_ff  <= s3_tag_ff.last_run;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign sts.run_done    = rsp_valid_ff && rsp_last_ff;

endmodule

/* src/matrix_multiply.sv */
`timescale 1ns / 1ps
// Matrix multiply top level: controller plus datapath.
// Depends on mm_pkg, mm_ctrl, mm_dp (and mm_ram below it).
//
// A load (req_type 0 or 1) is taken while busy is low and busy stays low, so
// loads can be issued every cycle while no compute runs. A compute keeps busy
// high while it walks every term, one multiply-accumulate per cycle, bounded by
// the single multiplier and one read port per store, and then through the store
// read, multiply, accumulate and result register stages. Product elements come
// out in row-major order, each on rsp_valid for exactly one cycle with no way
// to hold them off; the last one carries rsp_last_of_run and busy falls after it.
// Dimension registers are written through csr_we/csr_index/csr_wdata; the user
// must write them only while busy is low, which the block itself does not enforce.
module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REQ_W-1:0]         req_type,
   input  logic [IDX_W-1:0]         req_element_row,
   input  logic [IDX_W-1:0]         req_element_col,
   input  logic signed [DATA_W-1:0] req_element_value,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                     rsp_last_of_run,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_wdata
);

   mm_cmd_type cmd;
   mm_sts_type sts;

   mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_row   (req_element_row),
      .req_element_col   (req_element_col),
      .req_element_value (req_element_value),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // results only appear inside a compute run
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a compute run");

   // the run ends right after its last item
   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !busy)
      else $error("busy held after last item");

   // an accepted compute starts a run
   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_COMPUTE |=> busy)
      else $error("compute not started");

   // loads never start a run
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_LOAD_A || req_type == REQ_LOAD_B) |=> !busy)
      else $error("load raised busy");

endmodule

/* tb/sv/matrix_multiply_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply: a directed table, then random load and compute runs,
// every product element checked against in-bench Q16.16 values. Depends on mm_pkg and the RTL.
module matrix_multiply_test;
   import mm_pkg::*;

   localparam int DIM           = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 300;
   localparam int PHASES        = 6;

   localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [PROD_W-1:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_LO = -64'sd2147483648;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              last;
   } product_elem_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [REQ_W-1:0]  code;    // request type, or register index for a write
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;   // element, or register data in the low bits
      logic              typed;   // single 1x1 result given below
      logic [DATA_W-1:0] result;
   } stim_row_type;

   localparam int N_DIRECTED = 30;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_CSR,  CSR_ROWS_A,    3'd0, 3'd0, 32'd1,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_INNER_DIM, 3'd0, 3'd0, 32'd1,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_COLS_B,    3'd0, 3'd0, 32'd1,         1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_A,    3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_B,    3'd0, 3'd0, 32'h0002_0000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'h0002_0000},
      '{ROW_ITEM, REQ_LOAD_A,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_B,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, REQ_LOAD_B,    3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000},
      '{ROW_ITEM, REQ_LOAD_A,    3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, REQ_LOAD_A,    3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_B,    3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
      // -2^-16 * 2^-16 floors to -1 lsb
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, REQ_UNUSED,    3'd0, 3'd0, 32'h1234_5678, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, REQ_LOAD_B,    3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_A,    3'd7, 3'd7, 32'h8000_0000, 1'b0, 32'h0},
      // zero dimensions act as one; the unused index changes nothing
      '{ROW_CSR,  CSR_ROWS_A,    3'd0, 3'd0, 32'd0,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_INNER_DIM, 3'd0, 3'd0, 32'd0,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_COLS_B,    3'd0, 3'd0, 32'd0,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_UNUSED,    3'd0, 3'd0, 32'd15,        1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_CSR,  CSR_ROWS_A,    3'd0, 3'd0, 32'd2,         1'b0, 32'h0},
      '{ROW_CSR,  CSR_COLS_B,    3'd0, 3'd0, 32'd2,         1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_A,    3'd1, 3'd0, 32'h0001_8000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_LOAD_B,    3'd0, 3'd1, 32'hFFFF_0000, 1'b0, 32'h0},
      '{ROW_ITEM, REQ_COMPUTE,   3'd0, 3'd0, 32'h0,         1'b0, 32'h0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [REQ_W-1:0]         req_type;
   logic [IDX_W-1:0]         req_element_row;
   logic [IDX_W-1:0]         req_element_col;
   logic signed [DATA_W-1:0] req_element_value;
   logic                     rsp_valid;
   logic [IDX_W-1:0]         rsp_out_row;
   logic [IDX_W-1:0]         rsp_out_col;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_last_of_run;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DIM_W-1:0]         csr_wdata;

   // bench copy of the block's state
   logic [DATA_W-1:0] first_store  [DIM*DIM];
   logic [DATA_W-1:0] second_store [DIM*DIM];
   bit                first_written  [DIM*DIM];
   bit                second_written [DIM*DIM];
   logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;

   product_elem_type pending_products [$];

   int items_sent, compute_runs, csr_writes, elements_checked, failures;
   int phase_items, idle_pct;

   matrix_multiply #(.MAX_DIM(DIM)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_element_row   (req_element_row),
      .req_element_col   (req_element_col),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int active_dim(input logic [DIM_W-1:0] v);
      if (v == '0)
         return 1;
      if (v > DIM)
         return DIM;
      return int'(v);
   endfunction

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;  // within +-2.0
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return DIM_W'($urandom_range(9, 15));
         2: return DIM_W'(DIM);
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Updates the stores on a load; on a compute queues every product element.
   task automatic model_request(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
      int nr, nk, nc, i, j, k;
      logic signed [PROD_W-1:0] acc, term;
      product_elem_type p;
      nr = active_dim(rows_reg);
      nk = active_dim(inner_reg);
      nc = active_dim(cols_reg);
      case (rt)
         REQ_LOAD_A: begin
            first_store[r*DIM+c]   = v;
            first_written[r*DIM+c] = 1'b1;
         end
         REQ_LOAD_B: begin
            second_store[r*DIM+c]   = v;
            second_written[r*DIM+c] = 1'b1;
         end
         REQ_COMPUTE: begin
            compute_runs++;
            for (i = 0; i < nr; i++) begin
               for (j = 0; j < nc; j++) begin
                  acc = '0;
                  for (k = 0; k < nk; k++) begin
                     term = PROD_W'($signed(first_store[i*DIM+k]))
                          * PROD_W'($signed(second_store[k*DIM+j]));
                     acc  = acc + (term >>> FRAC_BITS);
                  end
                  if (acc > SAT_HI)
                     acc = SAT_HI;
                  else if (acc < SAT_LO)
                     acc = SAT_LO;
                  p.row   = IDX_W'(i);
                  p.col   = IDX_W'(j);
                  p.value = acc[DATA_W-1:0];
                  p.last  = (i == nr - 1) && (j == nc - 1);
                  pending_products.push_back(p);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Holds start until the block takes the item.
   task automatic send_item(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
      start             <= 1'b1;
      req_type          <= rt;
      req_element_row   <= r;
      req_element_col   <= c;
      req_element_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Waits for every queued element and for busy to fall, idles with start low, then flags any missing ones.
   task automatic settle();
      int waited;
      waited = 0;
      start <= 1'b0;
      while ((pending_products.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_products.size() != 0) begin
         $display("%0t: expected %0d more product elements, got none (next row %0d col %0d)",
                  $time, pending_products.size(), pending_products[0].row,
                  pending_products[0].col);
         failures++;
         pending_products.delete();
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROWS_A:    rows_reg  = d;
         CSR_INNER_DIM: inner_reg = d;
         CSR_COLS_B:    cols_reg  = d;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic issue(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] r,
                        input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
      send_item(rt, r, c, v);
      model_request(rt, r, c, v);
      if (rt != REQ_UNUSED) begin
         items_sent++;
         phase_items++;
      end
      if ($urandom_range(0, 99) < idle_pct)
         pause($urandom_range(1, 6));
   endtask

   // Loads whatever the current shape reads and has not been written, then computes.
   task automatic compute_run();
      int nr, nk, nc, i, j, k;
      nr = active_dim(rows_reg);
      nk = active_dim(inner_reg);
      nc = active_dim(cols_reg);
      for (i = 0; i < nr; i++)
         for (k = 0; k < nk; k++)
            if (!first_written[i*DIM+k])
               issue(REQ_LOAD_A, IDX_W'(i), IDX_W'(k), rand_value());
      for (k = 0; k < nk; k++)
         for (j = 0; j < nc; j++)
            if (!second_written[k*DIM+j])
               issue(REQ_LOAD_B, IDX_W'(k), IDX_W'(j), rand_value());
      issue(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
   endtask

   task automatic loaded_run();
      int nr, nk, nc;
      nr = active_dim(rows_reg);
      nk = active_dim(inner_reg);
      nc = active_dim(cols_reg);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 1))
            issue(REQ_LOAD_A, IDX_W'($urandom_range(0, nr - 1)),
                  IDX_W'($urandom_range(0, nk - 1)), rand_value());
         else
            issue(REQ_LOAD_B, IDX_W'($urandom_range(0, nk - 1)),
                  IDX_W'($urandom_range(0, nc - 1)), rand_value());
      end
      compute_run();
   endtask

   // Loads anywhere in the stores, unused request types and compute runs
   task automatic noise_burst();
      int t;
      repeat ($urandom_range(1, 5)) begin
         t = $urandom_range(0, 3);
         if (t == REQ_COMPUTE)
            compute_run();
         else
            issue(REQ_W'(t), IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end
   endtask

   always @(posedge clock) begin : product_check
      product_elem_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         elements_checked++;
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected product element row %0d col %0d value %h", $time,
                     rsp_out_row, rsp_out_col, rsp_out_value);
            failures++;
         end else begin
            want = pending_products.pop_front();
            if (rsp_out_row !== want.row) begin
               $display("%0t: row expected %0d got %0d", $time, want.row, rsp_out_row);
               failures++;
            end
            if (rsp_out_col !== want.col) begin
               $display("%0t: col expected %0d got %0d", $time, want.col, rsp_out_col);
               failures++;
            end
            if (rsp_out_value !== want.value) begin
               $display("%0t: value at (%0d,%0d) expected %h got %h", $time, want.row,
                        want.col, want.value, rsp_out_value);
               failures++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run at (%0d,%0d) expected %b got %b", $time, want.row,
                        want.col, want.last, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type     step_row;
      product_elem_type typed_elem;
      int               n, phase;
      logic [DIM_W-1:0] r_cfg, k_cfg, c_cfg;

      reset             = 1'b1;
      start             = 1'b0;
      req_type          = REQ_LOAD_A;
      req_element_row   = '0;
      req_element_col   = '0;
      req_element_value = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_ROWS_A;
      csr_wdata         = '0;
      rows_reg          = DIM_RESET;
      inner_reg         = DIM_RESET;
      cols_reg          = DIM_RESET;
      idle_pct          = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < N_DIRECTED; n++) begin
         step_row = DIRECTED[n];
         if (step_row.kind == ROW_CSR) begin
            settle();
            csr_write(step_row.code, step_row.value[DIM_W-1:0]);
         end else begin
            send_item(step_row.code, step_row.row, step_row.col, step_row.value);
            if (step_row.typed) begin
               typed_elem.row   = '0;
               typed_elem.col   = '0;
               typed_elem.value = step_row.result;
               typed_elem.last  = 1'b1;
               pending_products.push_back(typed_elem);
               compute_runs++;
            end else begin
               model_request(step_row.code, step_row.row, step_row.col, step_row.value);
            end
            if (step_row.code != REQ_UNUSED)
               items_sent++;
         end
      end

      // phase 0 and 3 run flat out, 1 and 4 idle most cycles, 2 and 5 now and then
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            1: begin
               r_cfg = 4'd15;
               k_cfg = 4'd1;
               c_cfg = 4'd8;
            end
            2: begin
               r_cfg = 4'd1;
               k_cfg = 4'd8;
               c_cfg = 4'd1;
            end
            default: begin
               r_cfg = pick_dim();
               k_cfg = pick_dim();
               c_cfg = pick_dim();
            end
         endcase
         csr_write(CSR_ROWS_A, r_cfg);
         csr_write(CSR_INNER_DIM, k_cfg);
         csr_write(CSR_COLS_B, c_cfg);
         if (phase == 4)
            csr_write(CSR_UNUSED, pick_dim());
         idle_pct    = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 81 : 21;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 99) < 85)
               loaded_run();
            else
               noise_burst();
         end
      end

      settle();
      $display("Sent %0d items: %0d compute runs across %0d register writes, with idle phases.",
               items_sent, compute_runs, csr_writes);
      $display("Compared %0d product elements, %0d failures.", elements_checked, failures);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
src/mm_pkg.sv
src/mm_ram.sv
src/mm_ctrl.sv
src/mm_dp.sv
src/matrix_multiply.sv
tb/sv/matrix_multiply_test.sv
